>>> rtl/core/edbp_pkg.sv
package edbp_pkg;

  // Width of a left-aligned bit string handed from the front to the back.
  // The longest delta code of a 64-bit value is 76 bits.
  localparam int DATA_W = 76;
  // Bit count of such a string, 0 to DATA_W.
  localparam int CNT_W = 7;
  // Jobs held between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Defaults for the top-level parameters.
  localparam int MAX_RAW_BITS_DEF = 32;
  localparam int COUNT_WIDTH_DEF = 32;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_DELTA = 2'd0;
  localparam logic [1:0] OP_RAW   = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  // One classified item: bits to write MSB first, or a pad request.
  typedef struct packed {
    logic              flush;
    logic              err;
    logic [CNT_W-1:0]  cnt;
    logic [DATA_W-1:0] data;
  } job_t;

  // Position of the leading one plus one; zero for a zero word.
  function automatic logic [6:0] bit_length64(input logic [63:0] v);
    logic [6:0] len;
    len = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        len = 7'(i + 1);
      end
    end
    return len;
  endfunction

  // Same for a seven-bit word.
  function automatic logic [2:0] bit_length7(input logic [6:0] v);
    logic [2:0] len;
    len = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (v[i]) begin
        len = 3'(i + 1);
      end
    end
    return len;
  endfunction

endpackage

>>> rtl/core/edbp_front.sv
module edbp_front #(
  parameter int MAX_RAW_BITS = edbp_pkg::MAX_RAW_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_op,
  input  logic [63:0]           in_value,
  input  logic [5:0]            in_length,
  output logic                  push,
  output edbp_pkg::job_t        push_job,
  input  logic                  queue_full
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LEN   = 2'd1;
  localparam logic [1:0] S_CODE  = 2'd2;
  localparam logic [1:0] S_ALIGN = 2'd3;

  localparam int DW = edbp_pkg::DATA_W;
  localparam int CW = edbp_pkg::CNT_W;

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    op_r;
  logic [63:0]   value_r;
  logic [5:0]    length_r;
  logic [6:0]    n_r;
  logic [6:0]    raw_len_r;
  logic          err_r;
  logic [DW-1:0] code_r;
  logic [CW-1:0] len_r;

  logic [6:0]    n_calc;
  logic [6:0]    raw_len_calc;
  logic [2:0]    lol;
  logic [63:0]   lead;
  logic [63:0]   raw_mask;
  logic [DW-1:0] delta_code;
  logic [CW-1:0] delta_len;
  logic [DW-1:0] code_calc;
  logic [CW-1:0] len_calc;

  // A new beat is taken only while no item is being classified.
  assign in_stall = (state_r != S_IDLE);

  // Bit length of the value and the saturated raw length.
  always_comb begin
    n_calc = edbp_pkg::bit_length64(value_r);
    if ({1'b0, length_r} > 7'(MAX_RAW_BITS)) begin
      raw_len_calc = 7'(MAX_RAW_BITS);
    end else begin
      raw_len_calc = {1'b0, length_r};
    end
  end

  // Right-aligned code and its length. The delta code is N in 2L-1 bits
  // followed by the value bits below the leading one.
  always_comb begin
    lol        = edbp_pkg::bit_length7(n_r);
    lead       = 64'd1 << 6'(n_r - 7'd1);
    delta_code = (DW'(n_r) << 6'(n_r - 7'd1)) | DW'(value_r ^ lead);
    delta_len  = CW'({lol, 1'b0}) + CW'(n_r) - CW'(2);
    if (raw_len_r == 7'd0) begin
      raw_mask = 64'd0;
    end else begin
      raw_mask = {64{1'b1}} >> (7'd64 - raw_len_r);
    end
    case (op_r)
      edbp_pkg::OP_DELTA: begin
        code_calc = delta_code;
        len_calc  = err_r ? CW'(0) : delta_len;
      end
      edbp_pkg::OP_RAW: begin
        code_calc = DW'(value_r & raw_mask);
        len_calc  = CW'(raw_len_r);
      end
      default: begin
        code_calc = '0;
        len_calc  = CW'(0);
      end
    endcase
  end

  // Left-align the code for the back and offer it to the queue.
  always_comb begin
    push_job.flush = (op_r == edbp_pkg::OP_FLUSH);
    push_job.err   = err_r;
    push_job.cnt   = len_r;
    push_job.data  = code_r << (CW'(DW) - len_r);
    push           = (state_r == S_ALIGN);
  end

  // Sequencer through the classify steps.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LEN;
        end
      end
      S_LEN:   state_nxt = S_CODE;
      S_CODE:  state_nxt = S_ALIGN;
      S_ALIGN: begin
        if (!queue_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item payload and intermediate results.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r     <= in_op;
      value_r  <= in_value;
      length_r <= in_length;
    end
    if (state_r == S_LEN) begin
      n_r       <= n_calc;
      raw_len_r <= raw_len_calc;
      err_r     <= (op_r == edbp_pkg::OP_DELTA) && (n_calc == 7'd0);
    end
    if (state_r == S_CODE) begin
      code_r <= code_calc;
      len_r  <= len_calc;
    end
  end

endmodule

>>> rtl/core/edbp_queue.sv
module edbp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  edbp_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output edbp_pkg::job_t head_job
);

  localparam int DEPTH = edbp_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = $clog2(DEPTH + 1);

  edbp_pkg::job_t entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic           do_push, do_pop;

  assign full     = (fill_r == FW'(DEPTH));
  assign empty    = (fill_r == FW'(0));
  assign head_job = entry_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + FW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> rtl/core/edbp_back.sv
module edbp_back #(
  parameter int COUNT_WIDTH = edbp_pkg::COUNT_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           empty,
  input  edbp_pkg::job_t head_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_byte_valid,
  output logic           out_error,
  output logic [31:0]    out_byte_count,
  output logic           out_last
);

  localparam int DW = edbp_pkg::DATA_W;
  localparam int CW = edbp_pkg::CNT_W;

  // Job under work.
  logic                   job_valid_r, job_valid_nxt;
  logic                   flush_r;
  logic                   err_r;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [DW-1:0]          data_r, data_nxt;
  // Unfinished byte, right-aligned, and its bit count.
  logic [6:0]             pb_r, pb_nxt;
  logic [2:0]             p_r, p_nxt;
  logic [COUNT_WIDTH-1:0] total_r, total_nxt;
  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             byte_r, byte_nxt;
  logic                   bvalid_r, bvalid_nxt;
  logic                   error_r, error_nxt;
  logic [31:0]            count_r, count_nxt;
  logic                   last_r, last_nxt;

  logic                   out_free;
  logic                   work;
  logic [CW-1:0]          avail;
  logic [CW-1:0]          rem;
  logic [14:0]            window;
  logic [7:0]             full_byte;
  logic [3:0]             take;
  logic [DW-1:0]          data_sh;
  logic [14:0]            merged;

  assign out_free = !out_valid_r || !out_stall;
  assign work     = job_valid_r && out_free;
  assign pop      = !job_valid_r && !empty;

  // Byte assembly from the pending bits and the head of the string.
  always_comb begin
    avail     = CW'(p_r) + cnt_r;
    rem       = avail - CW'(8);
    window    = {pb_r, data_r[DW-1 -: 8]};
    full_byte = 8'(window >> p_r);
    take      = 4'd8 - {1'b0, p_r};
    data_sh   = data_r << take;
    merged    = window >> (4'd8 - cnt_r[3:0]);
  end

  // One result per cycle while a job is loaded and the output is free.
  always_comb begin
    job_valid_nxt = job_valid_r;
    cnt_nxt       = cnt_r;
    data_nxt      = data_r;
    pb_nxt        = pb_r;
    p_nxt         = p_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && out_stall;
    byte_nxt      = byte_r;
    bvalid_nxt    = bvalid_r;
    error_nxt     = error_r;
    last_nxt      = last_r;

    if (work) begin
      out_valid_nxt = 1'b1;
      error_nxt     = 1'b0;
      if (flush_r) begin
        // Pad the partial byte with zeros, if there is one.
        job_valid_nxt = 1'b0;
        last_nxt      = 1'b1;
        if (p_r != 3'd0) begin
          byte_nxt   = full_byte;
          bvalid_nxt = 1'b1;
          total_nxt  = total_r + COUNT_WIDTH'(1);
          p_nxt      = 3'd0;
          pb_nxt     = 7'd0;
        end else begin
          byte_nxt   = 8'd0;
          bvalid_nxt = 1'b0;
        end
      end else if (avail >= CW'(8)) begin
        // A full byte; leftover bits below a byte go to the partial byte.
        byte_nxt   = full_byte;
        bvalid_nxt = 1'b1;
        total_nxt  = total_r + COUNT_WIDTH'(1);
        data_nxt   = data_sh;
        if (rem < CW'(8)) begin
          job_valid_nxt = 1'b0;
          last_nxt      = 1'b1;
          pb_nxt        = data_sh[DW-1 -: 7] >> (3'd7 - rem[2:0]);
          p_nxt         = rem[2:0];
          cnt_nxt       = CW'(0);
        end else begin
          last_nxt = 1'b0;
          p_nxt    = 3'd0;
          cnt_nxt  = rem;
        end
      end else begin
        // No byte completes: merge the bits into the partial byte.
        job_valid_nxt = 1'b0;
        last_nxt      = 1'b1;
        byte_nxt      = 8'd0;
        bvalid_nxt    = 1'b0;
        error_nxt     = err_r;
        pb_nxt        = merged[6:0];
        p_nxt         = avail[2:0];
      end
    end

    if (pop) begin
      job_valid_nxt = 1'b1;
      cnt_nxt       = head_job.cnt;
      data_nxt      = head_job.data;
    end
    count_nxt = 32'(total_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      pb_r        <= 7'd0;
      p_r         <= 3'd0;
      total_r     <= '0;
    end else begin
      job_valid_r <= job_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pb_r        <= pb_nxt;
      p_r         <= p_nxt;
      total_r     <= total_nxt;
    end
  end

  // Job payload and result fields.
  always_ff @(posedge clk) begin
    if (pop) begin
      flush_r <= head_job.flush;
      err_r   <= head_job.err;
    end
    cnt_r  <= cnt_nxt;
    data_r <= data_nxt;
    if (work) begin
      byte_r   <= byte_nxt;
      bvalid_r <= bvalid_nxt;
      error_r  <= error_nxt;
      count_r  <= count_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bvalid_r;
  assign out_error      = error_r;
  assign out_byte_count = count_r;
  assign out_last       = last_r;

endmodule

>>> rtl/core/elias_delta_bit_packer.sv
// Elias-delta bit packer.
// Input channel (in_valid / in_stall): one beat carries in_op, in_value and
// in_length. Op 0 writes the Elias-delta code of in_value, op 1 writes the
// low in_length bits of in_value (saturated to MAX_RAW_BITS), op 2 pads
// the partial byte with zeros. Bits are packed MSB first.
// Result channel (out_valid / out_stall): one beat per completed byte with
// the running byte count; an item that completes no byte yields one beat
// with out_byte_valid low. out_last marks the final beat of each item and
// out_error flags a delta code of zero.
// Timing: the front classifies an item in four steps (accept, bit length,
// code build, align) and takes no new beat until the item is in the queue.
// The back loads a job from the queue and then emits one byte per cycle
// while the receiver does not stall; a 76-bit delta code on top of seven
// pending bits gives ten bytes.
// A two-entry job queue lets front and back stall independently; when the
// receiver stalls, the output register holds and the queue fills.
// Reset (synchronous, rst_n low) empties the queue and clears the partial
// byte and the byte count.
module elias_delta_bit_packer #(
  parameter int MAX_RAW_BITS = edbp_pkg::MAX_RAW_BITS_DEF,
  parameter int COUNT_WIDTH  = edbp_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_value,
  input  logic [5:0]  in_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_error,
  output logic [31:0] out_byte_count,
  output logic        out_last
);

  logic           push;
  logic           queue_full;
  logic           pop;
  logic           queue_empty;
  edbp_pkg::job_t push_job;
  edbp_pkg::job_t head_job;

  // Classification of input beats into bit-string jobs.
  edbp_front #(
    .MAX_RAW_BITS (MAX_RAW_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_value   (in_value),
    .in_length  (in_length),
    .push       (push),
    .push_job   (push_job),
    .queue_full (queue_full)
  );

  // Job queue between the two halves.
  edbp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head_job (head_job)
  );

  // Byte packing and result output.
  edbp_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (queue_empty),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_error      (out_error),
    .out_byte_count (out_byte_count),
    .out_last       (out_last)
  );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import edbp_pkg::*;

  localparam int RAW_LIMIT    = MAX_RAW_BITS_DEF;
  localparam int COUNT_BITS   = COUNT_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 390;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 150;
  // The fourth operation code has no function and must be ignored.
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] value;
    logic [5:0]  length;
    bit          drain_first;
  } pack_item_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        bvalid;
    logic        err;
    logic [31:0] count;
    logic        last;
  } byte_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = OP_DELTA;
  logic [63:0] in_value = '0;
  logic [5:0]  in_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_error;
  logic [31:0] out_byte_count;
  logic        out_last;

  pack_item_t item_q[$];
  byte_beat_t packed_beats_q[$];
  pack_item_t cur_item;

  // Shadow of the packer state.
  logic [6:0]  pend_bits = '0;
  logic [2:0]  pend_n = '0;
  logic [31:0] bytes_out = '0;
  int          item_beats;

  int  n_fail = 0;
  int  n_sent = 0;
  int  n_beats = 0;
  int  n_bytes = 0;
  int  n_zero_err = 0;
  int  n_ops[4] = '{0, 0, 0, 0};
  int  cycles = 0;
  int  send_wait;
  int  recv_wait;
  int  hold_left;
  int  holds_done = 0;
  bit  send_burst = 1'b0;
  bit  recv_burst = 1'b0;

  elias_delta_bit_packer #(
    .MAX_RAW_BITS(RAW_LIMIT),
    .COUNT_WIDTH (COUNT_BITS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_value      (in_value),
    .in_length     (in_length),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_byte_valid(out_byte_valid),
    .out_error     (out_error),
    .out_byte_count(out_byte_count),
    .out_last      (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Number of significant bits of a word, zero for zero.
  function automatic int bit_width(input logic [63:0] v);
    int w;
    w = 0;
    while (v != 0) begin
      v = v >> 1;
      w++;
    end
    return w;
  endfunction

  // Appends one bit to the partial byte and predicts a beat when it fills.
  function automatic void shift_in_bit(input logic b);
    logic [7:0] acc;
    byte_beat_t r;
    acc = {pend_bits, b};
    if (pend_n == 3'd7) begin
      bytes_out = bytes_out + 32'd1;
      r = '{data: acc, bvalid: 1'b1, err: 1'b0, count: bytes_out, last: 1'b0};
      packed_beats_q.push_back(r);
      item_beats++;
      pend_bits = '0;
      pend_n = '0;
    end else begin
      pend_bits = acc[6:0];
      pend_n = pend_n + 3'd1;
    end
  endfunction

  // Predicts every beat that one accepted item causes.
  function automatic void pack_item(input pack_item_t it);
    int nbits;
    int lol;
    int cnt;
    logic err;
    byte_beat_t r;
    item_beats = 0;
    err = 1'b0;
    case (it.op)
      OP_DELTA: begin
        if (it.value == 0) begin
          err = 1'b1;
        end else begin
          nbits = bit_width(it.value);
          lol = bit_width(64'(nbits));
          for (int i = 1; i < lol; i++) shift_in_bit(1'b0);
          for (int i = lol - 1; i >= 0; i--) shift_in_bit(nbits[i]);
          for (int i = nbits - 2; i >= 0; i--) shift_in_bit(it.value[i]);
        end
      end
      OP_RAW: begin
        cnt = (int'(it.length) > RAW_LIMIT) ? RAW_LIMIT : int'(it.length);
        for (int i = cnt - 1; i >= 0; i--) shift_in_bit(it.value[i]);
      end
      OP_FLUSH: begin
        while (pend_n != 0) shift_in_bit(1'b0);
      end
      default: begin
      end
    endcase
    // An item that completes no byte still yields one marker beat.
    if (item_beats == 0) begin
      r = '{data: 8'd0, bvalid: 1'b0, err: err, count: bytes_out, last: 1'b1};
      packed_beats_q.push_back(r);
    end else begin
      r = packed_beats_q.pop_back();
      r.last = 1'b1;
      packed_beats_q.push_back(r);
    end
  endfunction

  function automatic void compare_field(input string what, input logic [31:0] want,
                                        input logic [31:0] seen);
    if (seen !== want) begin
      n_fail++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
    end
  endfunction

  function automatic void add_item(input logic [1:0] op, input logic [63:0] value,
                                   input logic [5:0] length, input bit drain_first);
    pack_item_t it;
    it.op = op;
    it.value = value;
    it.length = length;
    it.drain_first = drain_first;
    item_q.push_back(it);
  endfunction

  // Driver: offers queued items, predicts on each accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_op <= OP_DELTA;
      in_value <= '0;
      in_length <= '0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        pack_item(cur_item);
        n_sent++;
        n_ops[cur_item.op]++;
        if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
        send_wait = send_burst ? 0 : $urandom_range(0, 9);
      end
      if (!(in_valid && in_stall)) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (item_q.size() != 0 &&
                     !(item_q[0].drain_first && packed_beats_q.size() != 0)) begin
          cur_item = item_q.pop_front();
          in_valid <= 1'b1;
          in_op <= cur_item.op;
          in_value <= cur_item.value;
          in_length <= cur_item.length;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls per beat, plus two long hold-offs.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 9);
      end
      if ((holds_done == 0 && n_sent >= 60) || (holds_done == 1 && n_sent >= 280)) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: each accepted beat is compared with the oldest prediction.
  always @(posedge clk) begin
    byte_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_beats++;
      if (out_byte_valid === 1'b1) n_bytes++;
      if (out_error === 1'b1) n_zero_err++;
      if (packed_beats_q.size() == 0) begin
        n_fail++;
        $display("%0t ns: unexpected beat, expected none, got byte %0h count %0h",
                 $time, out_byte, out_byte_count);
      end else begin
        want = packed_beats_q.pop_front();
        compare_field("out_byte", 32'(want.data), 32'(out_byte));
        compare_field("out_byte_valid", 32'(want.bvalid), 32'(out_byte_valid));
        compare_field("out_error", 32'(want.err), 32'(out_error));
        compare_field("out_byte_count", want.count, out_byte_count);
        compare_field("out_last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d items sent, %0d beats still expected",
               $time, n_sent, packed_beats_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [63:0] v;
    int pick;

    // Directed part: field extremes, every operation and the corner cases.
    add_item(OP_DELTA, 64'd1, 6'd0, 1'b0);
    add_item(OP_DELTA, 64'd2, 6'd0, 1'b0);
    add_item(OP_DELTA, 64'd3, 6'd0, 1'b0);
    add_item(OP_DELTA, 64'd16, 6'd0, 1'b0);
    add_item(OP_DELTA, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b0);
    add_item(OP_DELTA, 64'h8000_0000_0000_0000, 6'd0, 1'b0);
    // A zero value cannot be delta coded and is flagged.
    add_item(OP_DELTA, 64'd0, 6'd0, 1'b0);
    add_item(OP_RAW, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 1'b0);
    add_item(OP_RAW, 64'd1, 6'd1, 1'b0);
    add_item(OP_RAW, 64'hFFFF_FFFF_FFFF_FFFF, 6'd32, 1'b0);
    // Lengths past the raw limit are clipped.
    add_item(OP_RAW, 64'hFFFF_FFFF_FFFF_FFFF, 6'd33, 1'b0);
    add_item(OP_RAW, 64'hA5A5_A5A5_5A5A_5A5A, 6'd63, 1'b0);
    add_item(OP_RAW, 64'd0, 6'd32, 1'b0);
    add_item(OP_RAW, 64'd5, 6'd3, 1'b0);
    add_item(OP_FLUSH, 64'd0, 6'd0, 1'b0);
    // Flushing with nothing pending writes nothing.
    add_item(OP_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b0);
    add_item(OP_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b0);
    add_item(OP_RAW, 64'h7F, 6'd7, 1'b0);
    add_item(OP_DELTA, 64'd0, 6'd63, 1'b0);
    add_item(OP_SPARE, 64'd0, 6'd0, 1'b0);
    add_item(OP_DELTA, 64'h0000_0001_0000_0000, 6'd0, 1'b0);
    add_item(OP_FLUSH, 64'd0, 6'd0, 1'b0);

    // Random part, mostly delta codes and raw writes of varied widths.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      v = {$urandom(), $urandom()};
      if (pick < 45) begin
        v = v >> $urandom_range(0, 63);
        if ($urandom_range(0, 29) == 0) v = '0;
        add_item(OP_DELTA, v, 6'($urandom_range(0, 63)), n == 0 || n == 120 || n == 300);
      end else if (pick < 80) begin
        add_item(OP_RAW, v, ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                                         : 6'($urandom_range(0, 32)),
                 n == 0 || n == 120 || n == 300);
      end else if (pick < 95) begin
        add_item(OP_FLUSH, v, 6'($urandom_range(0, 63)), n == 0 || n == 120 || n == 300);
      end else begin
        add_item(OP_SPARE, v, 6'($urandom_range(0, 63)), n == 0 || n == 120 || n == 300);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (item_q.size() != 0 || in_valid || packed_beats_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (packed_beats_q.size() != 0) begin
      n_fail++;
      $display("%0t ns: %0d predicted beats never arrived", $time, packed_beats_q.size());
    end
    $display("Packed %0d items: %0d delta, %0d raw, %0d flush, %0d unused op.",
             n_sent, n_ops[OP_DELTA], n_ops[OP_RAW], n_ops[OP_FLUSH], n_ops[OP_SPARE]);
    $display("Checked %0d result beats, %0d full bytes, %0d zero-value flags.",
             n_beats, n_bytes, n_zero_err);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
